// ----- design/keyboard_press_repeat_queue_assert.svh -----
// Assertion macros used by the checker of the keyboard press repeat queue.
// Each macro expands to one labeled concurrent assertion that is clocked on the
// rising edge and switched off while reset is asserted.
`ifndef KEYBOARD_PRESS_REPEAT_QUEUE_ASSERT_SVH
`define KEYBOARD_PRESS_REPEAT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define KPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard queue check failed");

`endif

// ----- design/kprq_pkg.sv -----
package kprq_pkg;

    // Key bitmap geometry. The bitmap is scanned one digit per cycle, a digit being held while it has more new keys.
    localparam int WORD_BITS  = 64;
    localparam int KEY_BITS   = 4 * WORD_BITS;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = KEY_BITS / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(DIGITS);
    localparam int DIG_IDX_W  = $clog2(DIGIT_W);
    localparam int HID_W      = DIG_CNT_W + DIG_IDX_W;

    localparam int CODE_W         = 8;
    localparam int RING_SLOTS_DEF = 8;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [1:0]        op_t;

    // Item operations.
    localparam op_t OP_FRAME = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    // Configuration register indexes and reset values.
    localparam int        CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
    localparam code_t     DELAY_RST  = 8'd20;
    localparam code_t     RATE_RST   = 8'd7;

    // HID usage code to PETSCII-style code. Unmapped keys give zero.
    function automatic code_t hid_to_code(input logic [HID_W-1:0] hid);
        code_t code;
        code = '0;
        if (hid >= 8'h04 && hid <= 8'h1D)
        begin
            code = 8'd61 + hid;
        end
        else if (hid >= 8'h1E && hid <= 8'h26)
        begin
            code = 8'd19 + hid;
        end
        else
        begin
            case (hid)
                8'h27:   code = 8'd48;
                8'h28:   code = 8'd13;
                8'h29:   code = 8'd3;
                8'h2B:   code = 8'd9;
                8'h2C:   code = 8'd32;
                8'h4F:   code = 8'h1D;
                8'h50:   code = 8'h9D;
                8'h51:   code = 8'h11;
                8'h52:   code = 8'h91;
                8'h3A:   code = 8'd133;
                8'h3B:   code = 8'd137;
                8'h3C:   code = 8'd134;
                8'h3D:   code = 8'd138;
                default: code = 8'h00;
            endcase
        end
        return code;
    endfunction

endpackage

// ----- design/kprq_ram.sv -----
module kprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/keyboard_press_repeat_queue.sv -----
// Keyboard press detector with typematic repeat and a small key-code queue.
// Input channel (in_valid/in_ready) carries one word per item: op selects a
// frame snapshot (a 256-bit HID key bitmap on key_bits_0..3), a read of the
// next queued code, or a clear of the queue and the held key. Every item
// yields exactly one result word on the output channel (out_valid/out_ready):
// the popped code for a read, zero for everything else or an empty queue.
// A frame walks the bitmap against the stored previous bitmap one 4-bit
// digit per cycle, all 64 digits, holding a digit while it has further new
// keys to take, then passes the repeat timer state and loads the output
// register. A read goes through a read state, since the queue RAM has a
// registered read port; a clear goes straight to the output register load.
// Only one item is in flight, so the digit scan sets the throughput.
// The result sits in an output register, so a stalled receiver does not stop
// the block from taking the next item; a finished item waits only if that
// register is still full. Reset empties the queue, clears the previous
// bitmap, the held key and the timer, and restores the repeat delay (20) and
// repeat rate (7). Configuration writes are taken at any time but are meant
// for when the block is idle.
module keyboard_press_repeat_queue #(
    parameter int RING_SLOTS = kprq_pkg::RING_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  kprq_pkg::op_t                    op,
    input  logic [kprq_pkg::WORD_BITS-1:0]   key_bits_0,
    input  logic [kprq_pkg::WORD_BITS-1:0]   key_bits_1,
    input  logic [kprq_pkg::WORD_BITS-1:0]   key_bits_2,
    input  logic [kprq_pkg::WORD_BITS-1:0]   key_bits_3,
    output logic                             out_valid,
    input  logic                             out_ready,
    output kprq_pkg::code_t                  key_code,
    input  logic                             cfg_wr_en,
    input  logic [kprq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kprq_pkg::CODE_W-1:0]      cfg_data
);

    import kprq_pkg::*;

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SLOTS - 1);
    localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(DIGITS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_TICK = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [KEY_BITS-1:0]  cur_reg, cur_next;
    logic [KEY_BITS-1:0]  prev_reg, prev_next;
    logic [DIG_CNT_W-1:0] dig_reg, dig_next;
    logic [DIGIT_W-1:0]   pend_reg, pend_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 nokey_reg, nokey_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    code_t                held_reg, held_next;
    code_t                timer_reg, timer_next;
    code_t                delay_reg, delay_next;
    code_t                rate_reg, rate_next;
    code_t                res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    code_t                key_code_reg, key_code_next;

    logic [DIGIT_W-1:0]   cur_dig;
    logic [DIGIT_W-1:0]   fresh;
    logic [DIGIT_W-1:0]   work;
    logic [DIGIT_W-1:0]   low_bit;
    logic [DIGIT_W-1:0]   remaining;
    logic [DIG_IDX_W-1:0] low_idx;
    code_t                scan_code;
    logic [PTR_W-1:0]     head_inc, tail_inc;
    logic                 push_req;
    code_t                push_code;
    logic                 push_ok;
    logic                 ram_we;
    logic [PTR_W-1:0]     ram_raddr;
    code_t                ram_rdata;
    logic                 accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;

    // The low digit of both shift registers lines up with bitmap digit dig_reg.
    // The first digit holds the no-key flag and the lock bits, never keys.
    assign cur_dig = cur_reg[DIGIT_W-1:0];
    assign fresh   = (dig_reg == '0) ? '0 : (cur_dig & ~prev_reg[DIGIT_W-1:0]);

    // New keys of one digit are taken lowest first, one per cycle.
    assign work      = pend_vld_reg ? pend_reg : fresh;
    assign low_bit   = work & (~work + 1'b1);
    assign remaining = work & ~low_bit;

    always_comb
    begin
        low_idx = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            if (work[i])
            begin
                low_idx = DIG_IDX_W'(i);
            end
        end
    end

    assign scan_code = hid_to_code({dig_reg, low_idx});

    // A push of a zero code, or into a full ring, is dropped.
    assign push_ok = push_req && (push_code != '0) && (tail_inc != head_reg);
    assign ram_we  = push_ok;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        dig_next       = dig_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        nokey_next     = nokey_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        timer_next     = timer_reg;
        delay_next     = delay_reg;
        rate_next      = rate_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        key_code_next  = key_code_reg;
        push_req       = 1'b0;
        push_code      = scan_code;
        ram_raddr      = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    case (op)
                        OP_FRAME:
                        begin
                            cur_next      = {key_bits_3, key_bits_2, key_bits_1, key_bits_0};
                            nokey_next    = key_bits_0[0];
                            dig_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        OP_READ:
                        begin
                            // The RAM latches the head address at this edge.
                            if (head_reg != tail_reg)
                            begin
                                head_next  = head_inc;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            held_next  = '0;
                            state_next = ST_FIN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (work != '0)
                begin
                    push_req  = 1'b1;
                    push_code = scan_code;
                    if (scan_code != '0)
                    begin
                        held_next  = scan_code;
                        timer_next = delay_reg;
                    end
                end
                if (remaining == '0)
                begin
                    // The new bitmap shifts into the previous-bitmap register
                    // from the top, so after the last digit it sits in place.
                    cur_next      = cur_reg >> DIGIT_W;
                    prev_next     = {cur_dig, prev_reg[KEY_BITS-1:DIGIT_W]};
                    pend_vld_next = 1'b0;
                    dig_next      = dig_reg + 1'b1;
                    if (dig_reg == DIG_LAST)
                    begin
                        state_next = ST_TICK;
                    end
                end
                else
                begin
                    pend_next     = remaining;
                    pend_vld_next = 1'b1;
                end
            end
            ST_TICK:
            begin
                if (nokey_reg)
                begin
                    held_next = '0;
                end
                else if (held_reg != '0)
                begin
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - 1'b1;
                    end
                    else
                    begin
                        push_req   = 1'b1;
                        push_code  = held_reg;
                        timer_next = rate_reg;
                    end
                end
                state_next = ST_FIN;
            end
            ST_READ:
            begin
                res_next   = ram_rdata;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    key_code_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_ok)
        begin
            tail_next = tail_inc;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DELAY: delay_next = cfg_data;
                REG_RATE:  rate_next  = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            dig_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            timer_reg     <= '0;
            delay_reg     <= DELAY_RST;
            rate_reg      <= RATE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            dig_reg       <= dig_next;
            pend_vld_reg  <= pend_vld_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            timer_reg     <= timer_next;
            delay_reg     <= delay_next;
            rate_reg      <= rate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pend_reg     <= pend_next;
        nokey_reg    <= nokey_next;
        res_reg      <= res_next;
        key_code_reg <= key_code_next;
    end

    kprq_ram #(
        .WIDTH (CODE_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (push_code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- design/kprq_checker.sv -----
`include "keyboard_press_repeat_queue_assert.svh"

module kprq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input kprq_pkg::op_t   op,
    input logic            out_valid,
    input logic            out_ready,
    input kprq_pkg::code_t key_code
);

    import kprq_pkg::*;

    logic ctrl_take;

    // A clear or an unused op taken while the output register is free.
    assign ctrl_take = in_valid && in_ready && op != OP_FRAME && op != OP_READ && !out_valid;

    // A result word that is not taken stays put.
    `KPRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(key_code))

    // Only one item is worked on at a time, so the input closes after a word.
    `KPRQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // A clear or an unused op returns a zero word, by way of the finish state,
    // when the output register is free.
    `KPRQ_ASSERT_NEXT(a_ctrl_zero, clk, rst_n, ctrl_take, ##1 (out_valid && key_code == '0))

endmodule

bind keyboard_press_repeat_queue kprq_checker u_kprq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_code  (key_code)
);
